// File: sv/cblc_pkg.sv
// ----------------------------------------------------------------------------
// cblc_pkg
// Shared types and constants of the colour box learn and classify unit.
// ----------------------------------------------------------------------------
package cblc_pkg;

   localparam int ACT_W  = 2;
   localparam int OBJ_W  = 3;
   localparam int CHAN_W = 8;
   localparam int MASK_W = 8;
   localparam int CFG_W  = 4;

   localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LEARN    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLASSIFY = 2'd2;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd1;

   localparam logic [CHAN_W-1:0] BOUND_LO_RESET = 8'hFF;
   localparam logic [CHAN_W-1:0] BOUND_HI_RESET = 8'h00;

   typedef struct packed {
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] c;
   } pixel_type;

   typedef struct packed {
      logic clear_en;
      logic learn_en;
   } box_ctl_type;

endpackage

// File: sv/cblc_if.sv
// ----------------------------------------------------------------------------
// cblc_req_if / cblc_rsp_if
// Valid/ready channels for requests and classification results.
// ----------------------------------------------------------------------------
interface cblc_req_if;
   logic                           valid;
   logic                           ready;
   logic [cblc_pkg::ACT_W-1:0]     action;
   logic [cblc_pkg::OBJ_W-1:0]     object_id;
   logic [cblc_pkg::CHAN_W-1:0]    chan_a;
   logic [cblc_pkg::CHAN_W-1:0]    chan_b;
   logic [cblc_pkg::CHAN_W-1:0]    chan_c;

   modport source (output valid, action, object_id, chan_a, chan_b, chan_c, input ready);
   modport sink   (input valid, action, object_id, chan_a, chan_b, chan_c, output ready);
endinterface

interface cblc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cblc_pkg::MASK_W-1:0]    match_mask;

   modport source (output valid, match_mask, input ready);
   modport sink   (input valid, match_mask, output ready);
endinterface

// File: sv/cblc_box.sv
// ----------------------------------------------------------------------------
// cblc_box
// One object's colour box: bounds storage, learn widening and containment test.
// ----------------------------------------------------------------------------
module cblc_box (
   input  logic                  clock,
   input  logic                  reset,
   input  cblc_pkg::box_ctl_type ctl,
   input  cblc_pkg::pixel_type   px,
   output logic                  match
);

   cblc_pkg::pixel_type lo_ff, lo_in;
   cblc_pkg::pixel_type hi_ff, hi_in;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (ctl.clear_en) begin
         lo_in = '{a: cblc_pkg::BOUND_LO_RESET, b: cblc_pkg::BOUND_LO_RESET,
                   c: cblc_pkg::BOUND_LO_RESET};
         hi_in = '{a: cblc_pkg::BOUND_HI_RESET, b: cblc_pkg::BOUND_HI_RESET,
                   c: cblc_pkg::BOUND_HI_RESET};
      end else if (ctl.learn_en) begin
         if (px.a < lo_ff.a) lo_in.a = px.a;
         if (px.b < lo_ff.b) lo_in.b = px.b;
         if (px.c < lo_ff.c) lo_in.c = px.c;
         if (px.a > hi_ff.a) hi_in.a = px.a;
         if (px.b > hi_ff.b) hi_in.b = px.b;
         if (px.c > hi_ff.c) hi_in.c = px.c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '{a: cblc_pkg::BOUND_LO_RESET, b: cblc_pkg::BOUND_LO_RESET,
                    c: cblc_pkg::BOUND_LO_RESET};
         hi_ff <= '{a: cblc_pkg::BOUND_HI_RESET, b: cblc_pkg::BOUND_HI_RESET,
                    c: cblc_pkg::BOUND_HI_RESET};
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // An empty box (lower above upper) fails these tests on its own.
   assign match = (px.a >= lo_ff.a) && (px.a <= hi_ff.a) &&
                  (px.b >= lo_ff.b) && (px.b <= hi_ff.b) &&
                  (px.c >= lo_ff.c) && (px.c <= hi_ff.c);

endmodule

// File: sv/colour_box_learn_classify_unit.sv
// ----------------------------------------------------------------------------
// colour_box_learn_classify_unit
// Learns per-object RGB bounding boxes and classifies pixels against them.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req      in         action, object_id, chan_a, chan_b, chan_c
//  rsp      out        match_mask (classify transactions only)
//  csr      in         active_objects write (enable + data)
//
//  One transaction is accepted per cycle unless a classify request waits in the
//  input register behind a stalled result. A request is captured in an input
//  register, and from there the per-object comparators update the boxes or
//  compute the mask into the output register. Reset empties every box and sets
//  active_objects to one. A stalled result holds the output register; the input
//  stage still drains clear and learn transactions behind it.
// ----------------------------------------------------------------------------
module colour_box_learn_classify_unit #(
   parameter int MAX_OBJECTS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   cblc_req_if.sink                     req,
   cblc_rsp_if.source                   rsp,
   input  logic                         csr_wr_en,
   input  logic [cblc_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int IDX_W = 6;

   logic [cblc_pkg::CFG_W-1:0]  active_ff;

   logic                        s1_valid_ff, s1_valid_in;
   logic [cblc_pkg::ACT_W-1:0]  s1_action_ff;
   logic [cblc_pkg::OBJ_W-1:0]  s1_obj_ff;
   cblc_pkg::pixel_type         s1_px_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cblc_pkg::MASK_W-1:0] rsp_mask_ff;

   logic                        s1_has_rsp;
   logic                        s1_go;
   logic                        req_fire;
   logic [MAX_OBJECTS-1:0]      lane_match;
   logic [MAX_OBJECTS-1:0]      lane_active;
   logic [cblc_pkg::MASK_W-1:0] mask;

   assign s1_has_rsp = s1_valid_ff && (s1_action_ff == cblc_pkg::ACT_CLASSIFY);
   assign s1_go      = s1_valid_ff && (!s1_has_rsp || !rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_go;
   assign req_fire   = req.valid && req.ready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= cblc_pkg::ACTIVE_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) active_ff <= csr_wr_data;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req.action;
         s1_obj_ff    <= req.object_id;
         s1_px_ff     <= '{a: req.chan_a, b: req.chan_b, c: req.chan_c};
      end
   end

   for (genvar j = 0; j < MAX_OBJECTS; j++) begin : g_lane
      localparam logic [IDX_W-1:0] IDX = IDX_W'(j);
      cblc_pkg::box_ctl_type ctl;

      // Object j is active when j < min(active_objects, MAX_OBJECTS).
      assign lane_active[j] = {{(IDX_W-cblc_pkg::CFG_W){1'b0}}, active_ff} > IDX;
      assign ctl.clear_en = s1_go && (s1_action_ff == cblc_pkg::ACT_CLEAR);
      assign ctl.learn_en = s1_go && (s1_action_ff == cblc_pkg::ACT_LEARN) &&
                            lane_active[j] &&
                            ({{(IDX_W-cblc_pkg::OBJ_W){1'b0}}, s1_obj_ff} == IDX);

      cblc_box u_box (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .px    (s1_px_ff),
         .match (lane_match[j])
      );
   end

   for (genvar k = 0; k < cblc_pkg::MASK_W; k++) begin : g_mask
      if (k < MAX_OBJECTS) begin : g_on
         assign mask[k] = lane_match[k] && lane_active[k];
      end else begin : g_off
         assign mask[k] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_has_rsp) rsp_mask_ff <= mask;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.match_mask = rsp_mask_ff;

endmodule
